// File: sv/fap_pkg.sv
// Shared types, codes, constants and packing helpers for the fire alarm panel sequencer.
`default_nettype none

package fap_pkg;

    // Smoke must persist for this many ticks before the panel goes to alarm.
    localparam int VERIFY_TARGET = 2;
    // Loop trouble codes above this value saturate to it.
    localparam int TROUBLE_MAX = 7;
    // Full-scale verify progress in percent.
    localparam int PCT_FULL = 100;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    // Panel modes.
    typedef enum logic [2:0] {
        MODE_IDLE     = 3'd0,
        MODE_VERIFY   = 3'd1,
        MODE_TROUBLE  = 3'd2,
        MODE_ALARM    = 3'd3,
        MODE_SILENCED = 3'd4
    } mode_t;

    // Evaluated zone alarm kinds.
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_SMOKE = 2'd1,
        KIND_PULL  = 2'd2
    } kind_t;

    // Commands issued to the rest of the panel.
    typedef enum logic [2:0] {
        CMD_MONITOR       = 3'd0,
        CMD_START_VERIFY  = 3'd1,
        CMD_ACTIVATE      = 3'd2,
        CMD_SILENCE       = 3'd3,
        CMD_LATCH_TROUBLE = 3'd4,
        CMD_RESET         = 3'd5
    } cmd_t;

    // One input beat.
    typedef struct packed {
        logic       silence_req;
        logic       reset_req;
        logic [2:0] trouble_code;
        logic [1:0] alarm_kind;
    } fap_item_t;

    // One result beat.
    typedef struct packed {
        logic [6:0] verify_progress;
        logic [2:0] shown_trouble;
        kind_t      shown_alarm;
        cmd_t       panel_command;
        mode_t      panel_state;
    } fap_result_t;

    // Progress lookup indexed by the verify tick count, built at elaboration.
    typedef logic [6:0] pct_lut_t [16];

    function automatic pct_lut_t build_pct_lut();
        pct_lut_t lut;
        int       p;
        for (int i = 0; i < 16; i++) begin
            p = (i * PCT_FULL) / VERIFY_TARGET;
            if (p > PCT_FULL) begin
                p = PCT_FULL;
            end
            lut[i] = 7'(p);
        end
        return lut;
    endfunction

    localparam pct_lut_t PCT_LUT = build_pct_lut();

    // Pull the fields of an input beat out of tdata.
    function automatic fap_item_t unpack_item(logic [IN_TDATA_W-1:0] data);
        fap_item_t item;
        item = data[6:0];
        return item;
    endfunction

    // Pack a result into tdata, zero filled to whole bytes.
    function automatic logic [OUT_TDATA_W-1:0] pack_result(fap_result_t res);
        return {6'd0, res};
    endfunction

    // Recover a result from tdata.
    function automatic fap_result_t unpack_result(logic [OUT_TDATA_W-1:0] data);
        fap_result_t res;
        res = data[17:0];
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/fap_in_reg.sv
// Input register of the panel sequencer: captures one beat from the slave side.
`default_nettype none

module fap_in_reg (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // Fields from bit 0: alarm_kind[1:0], trouble_code[4:2], reset_req[5],
    // silence_req[6], zero[7].
    input  wire logic [fap_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                          advance,
    output logic                               item_valid,
    output fap_pkg::fap_item_t                 item
);
    import fap_pkg::*;

    logic      valid_reg;
    fap_item_t item_reg;

    // The register can take a beat when empty or when its content moves on.
    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    // Payload, loaded on each accepted beat.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= unpack_item(s_tdata);
        end
    end

endmodule

`default_nettype wire

// File: sv/fap_step.sv
// Panel state registers and the single-pass next-state and result logic.
`default_nettype none

module fap_step (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire fap_pkg::fap_item_t item,
    output fap_pkg::fap_result_t    result
);
    import fap_pkg::*;

    mode_t      mode_reg, mode_next;
    kind_t      held_alarm_reg, held_alarm_next;
    logic [2:0] held_trouble_reg, held_trouble_next;
    logic [3:0] verify_ticks_reg, verify_ticks_next;

    kind_t      kind;
    logic [2:0] trb;
    logic [2:0] vis_trb;
    cmd_t       cmd;
    kind_t      shown;
    logic [2:0] shown_trb;
    logic [6:0] progress;

    // Clean up the inputs: the undefined kind reads as none, trouble saturates.
    always_comb
    begin
        if (item.alarm_kind == KIND_SMOKE)
        begin
            kind = KIND_SMOKE;
        end
        else if (item.alarm_kind == KIND_PULL)
        begin
            kind = KIND_PULL;
        end
        else
        begin
            kind = KIND_NONE;
        end
        if (32'(item.trouble_code) > TROUBLE_MAX)
        begin
            trb = TROUBLE_MAX[2:0];
        end
        else
        begin
            trb = item.trouble_code;
        end
        vis_trb = (trb != 3'd0) ? trb : held_trouble_reg;
    end

    // Next state and the command of this tick.
    always_comb
    begin
        mode_next         = mode_reg;
        held_alarm_next   = held_alarm_reg;
        held_trouble_next = held_trouble_reg;
        verify_ticks_next = verify_ticks_reg;
        cmd               = CMD_MONITOR;
        shown             = KIND_NONE;
        shown_trb         = 3'd0;

        case (mode_reg)
            MODE_ALARM, MODE_SILENCED:
            begin
                if (kind == KIND_PULL)
                begin
                    held_alarm_next = KIND_PULL;
                end
                if (trb != 3'd0)
                begin
                    held_trouble_next = trb;
                end
                if (item.reset_req && kind == KIND_NONE)
                begin
                    // Reset clears the alarm; open trouble keeps the panel in trouble.
                    held_alarm_next   = KIND_NONE;
                    verify_ticks_next = 4'd0;
                    if (trb == 3'd0)
                    begin
                        held_trouble_next = 3'd0;
                        mode_next         = MODE_IDLE;
                        cmd               = CMD_RESET;
                    end
                    else
                    begin
                        mode_next = MODE_TROUBLE;
                        cmd       = CMD_LATCH_TROUBLE;
                        shown_trb = trb;
                    end
                end
                else if (mode_reg == MODE_SILENCED && kind == KIND_PULL &&
                         held_alarm_reg != KIND_PULL)
                begin
                    // A new manual pull while silenced sounds the NACs again.
                    mode_next = MODE_ALARM;
                    cmd       = CMD_ACTIVATE;
                    shown     = KIND_PULL;
                    shown_trb = vis_trb;
                end
                else if (mode_reg == MODE_ALARM && item.silence_req)
                begin
                    mode_next = MODE_SILENCED;
                    cmd       = CMD_SILENCE;
                    shown     = held_alarm_next;
                    shown_trb = vis_trb;
                end
                else
                begin
                    cmd       = (mode_reg == MODE_ALARM) ? CMD_ACTIVATE : CMD_SILENCE;
                    shown     = held_alarm_next;
                    shown_trb = vis_trb;
                end
            end
            MODE_IDLE, MODE_VERIFY, MODE_TROUBLE:
            begin
                if (kind == KIND_PULL)
                begin
                    // A manual pull alarms at once from any quiet mode.
                    mode_next         = MODE_ALARM;
                    held_alarm_next   = KIND_PULL;
                    held_trouble_next = vis_trb;
                    verify_ticks_next = 4'd0;
                    cmd               = CMD_ACTIVATE;
                    shown             = KIND_PULL;
                    shown_trb         = vis_trb;
                end
                else if (mode_reg == MODE_TROUBLE)
                begin
                    if (trb != 3'd0)
                    begin
                        held_trouble_next = trb;
                    end
                    if (item.reset_req && trb == 3'd0)
                    begin
                        mode_next         = MODE_IDLE;
                        held_trouble_next = 3'd0;
                        verify_ticks_next = 4'd0;
                        cmd               = CMD_RESET;
                    end
                    else
                    begin
                        cmd       = CMD_LATCH_TROUBLE;
                        shown_trb = (trb != 3'd0) ? trb : held_trouble_reg;
                    end
                end
                else if (trb != 3'd0)
                begin
                    mode_next         = MODE_TROUBLE;
                    held_trouble_next = trb;
                    verify_ticks_next = 4'd0;
                    cmd               = CMD_LATCH_TROUBLE;
                    shown_trb         = trb;
                end
                else if (mode_reg == MODE_IDLE)
                begin
                    if (kind == KIND_SMOKE)
                    begin
                        mode_next         = MODE_VERIFY;
                        verify_ticks_next = 4'd1;
                        cmd               = CMD_START_VERIFY;
                        shown             = KIND_SMOKE;
                    end
                end
                else if (kind != KIND_SMOKE)
                begin
                    // Smoke cleared before it was verified.
                    mode_next         = MODE_IDLE;
                    verify_ticks_next = 4'd0;
                end
                else if (({1'b0, verify_ticks_reg} + 5'd1) >= 5'(VERIFY_TARGET))
                begin
                    // Smoke persisted long enough.
                    mode_next         = MODE_ALARM;
                    held_alarm_next   = KIND_SMOKE;
                    verify_ticks_next = 4'd0;
                    cmd               = CMD_ACTIVATE;
                    shown             = KIND_SMOKE;
                    shown_trb         = held_trouble_reg;
                end
                else
                begin
                    verify_ticks_next = verify_ticks_reg + 4'd1;
                    cmd               = CMD_START_VERIFY;
                    shown             = KIND_SMOKE;
                end
            end
            default:
            begin
                cmd = CMD_MONITOR;
            end
        endcase
    end

    // Progress follows the mode and tick count after this tick.
    always_comb
    begin
        if (mode_next == MODE_VERIFY)
        begin
            progress = PCT_LUT[verify_ticks_next];
        end
        else if ((mode_next == MODE_ALARM || mode_next == MODE_SILENCED) &&
                 shown == KIND_SMOKE)
        begin
            progress = 7'(PCT_FULL);
        end
        else
        begin
            progress = 7'd0;
        end
    end

    assign result.panel_state     = mode_next;
    assign result.panel_command   = cmd;
    assign result.shown_alarm     = shown;
    assign result.shown_trouble   = shown_trb;
    assign result.verify_progress = progress;

    // Panel state, updated once per beat that moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            held_alarm_reg   <= KIND_NONE;
            held_trouble_reg <= 3'd0;
            verify_ticks_reg <= 4'd0;
        end
        else if (advance)
        begin
            mode_reg         <= mode_next;
            held_alarm_reg   <= held_alarm_next;
            held_trouble_reg <= held_trouble_next;
            verify_ticks_reg <= verify_ticks_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/fap_out_reg.sv
// Result register of the panel sequencer: holds one beat for the master side.
`default_nettype none

module fap_out_reg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           load,
    input  wire fap_pkg::fap_result_t           result,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: panel_state[2:0], panel_command[5:3], shown_alarm[7:6],
    // shown_trouble[10:8], verify_progress[17:11], zero[23:18].
    output logic [fap_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import fap_pkg::*;

    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] data_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    // Valid flag: set on load, cleared when the beat is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Payload.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= pack_result(result);
        end
    end

endmodule

`default_nettype wire

// File: sv/fire_alarm_panel_sequencer_unit.sv
// Top level of the fire alarm panel sequencer.
//
// Each slave beat carries one evaluated loop condition: the zone alarm kind,
// the loop trouble code and the operator reset and silence requests. Each
// beat yields exactly one master beat with the panel state, the command,
// the shown alarm and trouble, and the smoke verify progress in percent.
//
// A beat is registered on input, stepped through the panel state logic and
// registered again on output, where its result waits on the master side until
// it is taken. One beat is taken per cycle while the master side takes
// results; the state update is a single short pass, so consecutive beats
// follow each other without gaps.
//
// When the receiver stalls, the result register holds its beat and the
// input register can still take one more beat; further beats wait.
// Reset (rst_n low) empties both registers and returns the panel to idle
// with no latched alarm or trouble and the verify count at zero.
`default_nettype none

module fire_alarm_panel_sequencer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: alarm_kind[1:0], trouble_code[4:2], reset_req[5],
    // silence_req[6], zero[7].
    input  wire logic [fap_pkg::IN_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // Fields from bit 0: panel_state[2:0], panel_command[5:3], shown_alarm[7:6],
    // shown_trouble[10:8], verify_progress[17:11], zero[23:18].
    output logic [fap_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import fap_pkg::*;

    logic        item_valid;
    logic        advance;
    fap_item_t   item;
    fap_result_t result;
    fap_result_t out_res;

    // A held beat moves on when the result register is empty or being drained.
    assign advance = item_valid && (!m_tvalid || m_tready);
    assign out_res = unpack_result(m_tdata);

    fap_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    fap_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    fap_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    // A beat that leaves the input register shows up as a result next cycle.
    a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("stepped beat did not reach the result register");

    // The verify state is only ever reported with the start verify command.
    a_verify_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res.panel_state == MODE_VERIFY) |->
        out_res.panel_command == CMD_START_VERIFY)
        else $error("verify state without start verify command");

    // A reset command leaves the panel idle with nothing shown.
    a_reset_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res.panel_command == CMD_RESET) |->
        (out_res.panel_state == MODE_IDLE && out_res.shown_trouble == 3'd0 &&
         out_res.shown_alarm == KIND_NONE))
        else $error("reset command with state or indications left");

    // Progress never exceeds full scale.
    a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> out_res.verify_progress <= 7'(PCT_FULL))
        else $error("verify progress above full scale");
`endif

endmodule

`default_nettype wire

// File: tb/fap_panel_checker.sv
// Scoreboard for the fire alarm panel sequencer: predicts every result beat and checks it.
`default_nettype none

module fap_panel_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [fap_pkg::IN_TDATA_W-1:0] s_tdata,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [fap_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                                  mismatches,
    output int                                  outcomes_due,
    output int                                  outcomes_checked
);

    import fap_pkg::*;

    // The undefined alarm kind encoding, read as no alarm.
    localparam logic [1:0] KIND_UNDEFINED = 2'd3;
    // Only the first few mismatches are printed; all of them are counted.
    localparam int PRINT_CAP = 30;

    // Shadow copy of the panel state.
    mode_t       panel_mode;
    kind_t       shadow_alarm;
    logic [2:0]  shadow_trouble;
    logic [3:0]  smoke_ticks;

    // Results predicted for accepted input beats, oldest first.
    fap_result_t panel_outcomes[$];

    // Print one mismatch line and count it.
    task automatic note_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
        begin
            $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatches++;
    endtask

    // Advance the shadow panel by one beat and return the result it must give.
    function automatic fap_result_t step_panel(input fap_item_t beat);
        fap_result_t res;
        kind_t       kind;
        kind_t       prior_alarm;
        kind_t       shown;
        cmd_t        cmd;
        logic [2:0]  trb;
        logic [2:0]  vis;
        int          pct;

        kind = (beat.alarm_kind == KIND_UNDEFINED) ? KIND_NONE : kind_t'(beat.alarm_kind);
        trb  = (int'(beat.trouble_code) > TROUBLE_MAX) ? 3'(TROUBLE_MAX) : beat.trouble_code;
        cmd   = CMD_MONITOR;
        shown = KIND_NONE;
        vis   = 3'd0;

        case (panel_mode)
            // Alarm and silenced share the latching and the reset rule.
            MODE_ALARM, MODE_SILENCED:
            begin
                prior_alarm = shadow_alarm;
                if (kind == KIND_PULL)
                begin
                    shadow_alarm = KIND_PULL;
                end
                if (trb != 3'd0)
                begin
                    shadow_trouble = trb;
                end
                if (beat.reset_req && kind == KIND_NONE)
                begin
                    shadow_alarm = KIND_NONE;
                    smoke_ticks  = 4'd0;
                    if (trb == 3'd0)
                    begin
                        shadow_trouble = 3'd0;
                        panel_mode     = MODE_IDLE;
                        cmd            = CMD_RESET;
                    end
                    else
                    begin
                        panel_mode     = MODE_TROUBLE;
                        shadow_trouble = trb;
                        cmd            = CMD_LATCH_TROUBLE;
                        vis            = trb;
                    end
                end
                else
                begin
                    vis   = (trb != 3'd0) ? trb : shadow_trouble;
                    shown = shadow_alarm;
                    // A new pull is judged against the alarm latched before this beat.
                    if (panel_mode == MODE_SILENCED && kind == KIND_PULL
                        && prior_alarm != KIND_PULL)
                    begin
                        panel_mode = MODE_ALARM;
                        cmd        = CMD_ACTIVATE;
                    end
                    else if (panel_mode == MODE_ALARM && beat.silence_req)
                    begin
                        panel_mode = MODE_SILENCED;
                        cmd        = CMD_SILENCE;
                    end
                    else
                    begin
                        cmd = (panel_mode == MODE_ALARM) ? CMD_ACTIVATE : CMD_SILENCE;
                    end
                end
            end

            MODE_IDLE, MODE_VERIFY, MODE_TROUBLE:
            begin
                if (kind == KIND_PULL)
                begin
                    // A manual pull alarms at once from any quiet mode.
                    panel_mode   = MODE_ALARM;
                    shadow_alarm = KIND_PULL;
                    if (trb != 3'd0)
                    begin
                        shadow_trouble = trb;
                    end
                    smoke_ticks = 4'd0;
                    cmd         = CMD_ACTIVATE;
                    shown       = KIND_PULL;
                    vis         = (trb != 3'd0) ? trb : shadow_trouble;
                end
                else if (panel_mode == MODE_TROUBLE)
                begin
                    if (trb != 3'd0)
                    begin
                        shadow_trouble = trb;
                    end
                    if (beat.reset_req && trb == 3'd0)
                    begin
                        panel_mode     = MODE_IDLE;
                        shadow_trouble = 3'd0;
                        smoke_ticks    = 4'd0;
                        cmd            = CMD_RESET;
                    end
                    else
                    begin
                        cmd = CMD_LATCH_TROUBLE;
                        vis = shadow_trouble;
                    end
                end
                else if (trb != 3'd0)
                begin
                    panel_mode     = MODE_TROUBLE;
                    shadow_trouble = trb;
                    smoke_ticks    = 4'd0;
                    cmd            = CMD_LATCH_TROUBLE;
                    vis            = trb;
                end
                else if (panel_mode == MODE_IDLE)
                begin
                    if (kind == KIND_SMOKE)
                    begin
                        panel_mode  = MODE_VERIFY;
                        smoke_ticks = 4'd1;
                        cmd         = CMD_START_VERIFY;
                        shown       = KIND_SMOKE;
                    end
                end
                else
                begin
                    // Verify: smoke has to hold for the whole verify count.
                    if (kind != KIND_SMOKE)
                    begin
                        panel_mode  = MODE_IDLE;
                        smoke_ticks = 4'd0;
                    end
                    else if (int'(smoke_ticks) + 1 >= VERIFY_TARGET)
                    begin
                        panel_mode   = MODE_ALARM;
                        shadow_alarm = KIND_SMOKE;
                        smoke_ticks  = 4'd0;
                        cmd          = CMD_ACTIVATE;
                        shown        = KIND_SMOKE;
                        vis          = shadow_trouble;
                    end
                    else
                    begin
                        smoke_ticks = smoke_ticks + 4'd1;
                        cmd         = CMD_START_VERIFY;
                        shown       = KIND_SMOKE;
                    end
                end
            end

            // A mode outside the legal set reports monitor and changes nothing.
            default: ;
        endcase

        // Progress is taken from the mode after the update, capped at full scale.
        pct = 0;
        if (panel_mode == MODE_VERIFY)
        begin
            pct = (int'(smoke_ticks) * PCT_FULL) / VERIFY_TARGET;
            if (pct > PCT_FULL)
            begin
                pct = PCT_FULL;
            end
        end
        else if ((panel_mode == MODE_ALARM || panel_mode == MODE_SILENCED)
                 && shown == KIND_SMOKE)
        begin
            pct = PCT_FULL;
        end

        res.panel_state     = panel_mode;
        res.panel_command   = cmd;
        res.shown_alarm     = shown;
        res.shown_trouble   = vis;
        res.verify_progress = 7'(pct);
        return res;
    endfunction

    // Watch both channels: predict on each input beat, compare on each result beat.
    always @(posedge clk or negedge rst_n)
    begin
        fap_result_t got;
        fap_result_t want;
        if (!rst_n)
        begin
            panel_mode     = MODE_IDLE;
            shadow_alarm   = KIND_NONE;
            shadow_trouble = 3'd0;
            smoke_ticks    = 4'd0;
            panel_outcomes.delete();
            outcomes_due <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                panel_outcomes.push_back(step_panel(fap_item_t'(s_tdata[6:0])));
            end
            if (m_tvalid && m_tready)
            begin
                got = fap_result_t'(m_tdata[17:0]);
                if (panel_outcomes.size() == 0)
                begin
                    note_mismatch("result beat with nothing expected, panel_state",
                                  int'(got.panel_state), -1);
                end
                else
                begin
                    want = panel_outcomes.pop_front();
                    if (got.panel_state != want.panel_state)
                    begin
                        note_mismatch("panel_state", int'(got.panel_state),
                                      int'(want.panel_state));
                    end
                    if (got.panel_command != want.panel_command)
                    begin
                        note_mismatch("panel_command", int'(got.panel_command),
                                      int'(want.panel_command));
                    end
                    if (got.shown_alarm != want.shown_alarm)
                    begin
                        note_mismatch("shown_alarm", int'(got.shown_alarm),
                                      int'(want.shown_alarm));
                    end
                    if (got.shown_trouble != want.shown_trouble)
                    begin
                        note_mismatch("shown_trouble", int'(got.shown_trouble),
                                      int'(want.shown_trouble));
                    end
                    if (got.verify_progress != want.verify_progress)
                    begin
                        note_mismatch("verify_progress", int'(got.verify_progress),
                                      int'(want.verify_progress));
                    end
                    if (m_tdata[fap_pkg::OUT_TDATA_W-1:18] != '0)
                    begin
                        note_mismatch("tdata fill bits",
                                      int'(m_tdata[fap_pkg::OUT_TDATA_W-1:18]), 0);
                    end
                end
                outcomes_checked <= outcomes_checked + 1;
            end
            outcomes_due <= panel_outcomes.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/tb_fire_alarm_panel_sequencer_unit.sv
// Testbench top for the fire alarm panel sequencer: stimulus, pacing and verdict.
`default_nettype none

module tb_fire_alarm_panel_sequencer_unit;

    import fap_pkg::*;

    localparam logic [1:0] KIND_UNDEFINED = 2'd3;
    localparam int PHASE_BEATS  = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_TICKS = 10;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_TDATA_W-1:0]    s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_TDATA_W-1:0]   m_tdata;

    int mismatches;
    int outcomes_due;
    int outcomes_checked;

    // Pacing: percent of cycles the sender idles and the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;
    int beats_sent = 0;

    fire_alarm_panel_sequencer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fap_panel_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatches       (mismatches),
        .outcomes_due     (outcomes_due),
        .outcomes_checked (outcomes_checked)
    );

    // Free-running clock.
    always #5 clk = ~clk;

    // Receiver backpressure.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Offer one beat after a random idle stretch and wait for it to be taken.
    task automatic drive_beat(input logic [1:0] kind, input logic [2:0] trb,
                              input logic rst_req, input logic sil_req);
        fap_item_t beat;
        beat.alarm_kind   = kind;
        beat.trouble_code = trb;
        beat.reset_req    = rst_req;
        beat.silence_req  = sil_req;
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, beat};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        beats_sent++;
    endtask

    // Hold the sender off until every predicted result has come back.
    task automatic drain_results();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outcomes_due != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    function automatic logic [2:0] some_trouble();
        return ($urandom_range(99) < 25) ? 3'($urandom_range(7, 1)) : 3'd0;
    endfunction

    // One random episode: mostly well-formed panel sequences, some noise.
    task automatic run_episode();
        int roll;
        int n;
        roll = $urandom_range(99);
        if (roll < 30)
        begin
            // Smoke that may or may not persist long enough to verify.
            n = $urandom_range(4, 1);
            repeat (n)
            begin
                drive_beat(KIND_SMOKE, 3'd0, ($urandom_range(9) == 0), 1'($urandom_range(1)));
            end
            if ($urandom_range(1))
            begin
                drive_beat(KIND_NONE, 3'd0, 1'b1, 1'b0);
            end
        end
        else if (roll < 60)
        begin
            // Alarm episode: entry, a mix of pulls and silences, then a reset.
            if ($urandom_range(1))
            begin
                drive_beat(KIND_PULL, some_trouble(), 1'($urandom_range(1)),
                           1'($urandom_range(1)));
            end
            else
            begin
                repeat (VERIFY_TARGET)
                begin
                    drive_beat(KIND_SMOKE, 3'd0, 1'b0, 1'b0);
                end
            end
            n = $urandom_range(3);
            repeat (n)
            begin
                drive_beat(2'($urandom_range(2)), some_trouble(),
                           ($urandom_range(4) == 0), 1'($urandom_range(1)));
            end
            drive_beat(KIND_NONE, some_trouble(), 1'b1, 1'($urandom_range(1)));
        end
        else if (roll < 80)
        begin
            // Trouble episode, cleared by a reset on a clear loop.
            drive_beat(KIND_NONE, 3'($urandom_range(7, 1)), 1'b0, 1'($urandom_range(1)));
            n = $urandom_range(3);
            repeat (n)
            begin
                drive_beat(($urandom_range(3) == 0) ? KIND_UNDEFINED : KIND_NONE,
                           some_trouble(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
            drive_beat(KIND_NONE, 3'd0, 1'b1, 1'b0);
        end
        else
        begin
            n = $urandom_range(3, 1);
            repeat (n)
            begin
                drive_beat(2'($urandom_range(3)), 3'($urandom_range(7)),
                           1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
    endtask

    // Main sequence: reset, directed beats, four paced random phases, verdict.
    initial
    begin
        int start_beats;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through every mode, command and corner of the panel.
        drive_beat(KIND_NONE,      3'd0, 1'b0, 1'b0);   // idle monitor
        drive_beat(KIND_SMOKE,     3'd0, 1'b0, 1'b0);   // start verify
        drive_beat(KIND_SMOKE,     3'd0, 1'b0, 1'b0);   // verified smoke alarm
        drive_beat(KIND_NONE,      3'd0, 1'b0, 1'b1);   // silence
        drive_beat(KIND_PULL,      3'd0, 1'b0, 1'b0);   // new pull re-activates
        drive_beat(KIND_NONE,      3'd0, 1'b0, 1'b1);   // silence again
        drive_beat(KIND_PULL,      3'd5, 1'b0, 1'b0);   // repeated pull stays silenced
        drive_beat(KIND_PULL,      3'd0, 1'b1, 1'b0);   // reset refused while pulled
        drive_beat(KIND_NONE,      3'd0, 1'b1, 1'b0);   // reset to idle
        drive_beat(KIND_NONE,      3'd7, 1'b0, 1'b0);   // top trouble code latches
        drive_beat(KIND_UNDEFINED, 3'd0, 1'b0, 1'b0);   // undefined kind reads as none
        drive_beat(KIND_NONE,      3'd2, 1'b1, 1'b0);   // reset with trouble still active
        drive_beat(KIND_NONE,      3'd0, 1'b1, 1'b0);   // reset from trouble
        drive_beat(KIND_SMOKE,     3'd0, 1'b0, 1'b0);
        drive_beat(KIND_NONE,      3'd0, 1'b0, 1'b0);   // smoke drops out of verify
        drive_beat(KIND_SMOKE,     3'd0, 1'b0, 1'b0);
        drive_beat(KIND_SMOKE,     3'd4, 1'b0, 1'b0);   // trouble during verify
        drive_beat(KIND_PULL,      3'd0, 1'b0, 1'b1);   // pull from trouble
        drive_beat(KIND_NONE,      3'd3, 1'b1, 1'b1);   // alarm reset into trouble
        drive_beat(KIND_UNDEFINED, 3'd0, 1'b1, 1'b1);   // clear with undefined kind
        drive_beat(KIND_PULL,      3'd7, 1'b1, 1'b1);   // every request bit set
        drive_beat(KIND_NONE,      3'd0, 1'b1, 1'b0);
        drain_results();

        // Random phases with different pacing, each drained before the next.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 55;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 55;
                end
                default:
                begin
                    idle_pct  = 36;
                    stall_pct = 36;
                end
            endcase
            start_beats = beats_sent;
            while (beats_sent - start_beats < PHASE_BEATS)
            begin
                run_episode();
            end
            drain_results();
        end

        stall_pct = 0;
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Run covered %0d input beats: directed corners, then smoke, alarm,",
                 beats_sent);
        $display("trouble and noise episodes under four pacing mixes; %0d results compared.",
                 outcomes_checked);
        if (mismatches == 0 && outcomes_due == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2000000;
        $display("Timeout: stimulus or results stopped moving.");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire
